// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, disabled while reset is high
`define SLI_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sli check failed");

// clocked implication, disabled while reset is high
`define SLI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sli implication failed");

`endif

// ===== design/sli_pkg.sv =====
// types, constants and microcode table of the sorted list insert block
package sli_pkg;

  localparam int POOL_SIZE = 64;
  localparam int KEY_BITS  = 32;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int PTR_W     = IDX_W + 1;
  localparam int RANK_W    = 7;
  localparam int STAT_W    = 2;
  localparam int STEP_W    = 3;
  localparam int COND_W    = 3;

  localparam logic [PTR_W-1:0] NONE_IDX = PTR_W'(POOL_SIZE);

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd2;

  // program steps
  localparam logic [STEP_W-1:0] S_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] S_CHECK  = 3'd1;
  localparam logic [STEP_W-1:0] S_WALK   = 3'd2;
  localparam logic [STEP_W-1:0] S_DECIDE = 3'd3;
  localparam logic [STEP_W-1:0] S_ALLOC  = 3'd4;
  localparam logic [STEP_W-1:0] S_LINK   = 3'd5;
  localparam logic [STEP_W-1:0] S_EMIT   = 3'd7;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER  = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] C_NOREQ  = 3'd2;
  localparam logic [COND_W-1:0] C_FULL   = 3'd3;
  localparam logic [COND_W-1:0] C_WALK   = 3'd4;
  localparam logic [COND_W-1:0] C_DUP    = 3'd5;
  localparam logic [COND_W-1:0] C_OBUSY  = 3'd6;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic                in_rdy;    // request channel open
    logic                adv;       // step along the list when jump taken
    logic                rsel_free; // read port addresses the free head
    logic                alloc;     // take free node, write key and link
    logic                link;      // hook fresh node after prev or at head
    logic                st_jmp;    // load status when jump taken
    logic [STAT_W-1:0]   st;
    logic                emit;      // hand result to output register
    logic [COND_W-1:0]   cond;
    logic [STEP_W-1:0]   jmp;
  } uword_t;

  // control store: taken jump goes to jmp, otherwise to the next step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    case (step)
      S_IDLE: begin
        w.in_rdy = 1'b1;
        w.cond   = C_NOREQ;
        w.jmp    = S_IDLE;
      end
      S_CHECK: begin
        w.st_jmp = 1'b1;
        w.st     = ST_FULL;
        w.cond   = C_FULL;
        w.jmp    = S_EMIT;
      end
      S_WALK: begin
        w.adv  = 1'b1;
        w.cond = C_WALK;
        w.jmp  = S_WALK;
      end
      S_DECIDE: begin
        w.rsel_free = 1'b1;
        w.st_jmp    = 1'b1;
        w.st        = ST_DUP;
        w.cond      = C_DUP;
        w.jmp       = S_EMIT;
      end
      S_ALLOC: begin
        w.alloc = 1'b1;
        w.cond  = C_NEVER;
        w.jmp   = S_IDLE;
      end
      S_LINK: begin
        w.link = 1'b1;
        w.cond = C_ALWAYS;
        w.jmp  = S_EMIT;
      end
      S_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OBUSY;
        w.jmp  = S_EMIT;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.jmp  = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/sli_if.sv =====
// handshake channels of the sorted list insert block
interface sli_req_if;
  logic                         valid;
  logic                         ready;
  logic [sli_pkg::KEY_BITS-1:0] new_key;

  modport source (output valid, output new_key, input ready);
  modport sink (input valid, input new_key, output ready);
endinterface

interface sli_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sli_pkg::STAT_W-1:0] status;
  logic [sli_pkg::RANK_W-1:0] rank;

  modport source (output valid, output status, output rank, input ready);
  modport sink (input valid, input status, input rank, output ready);
endinterface

// ===== design/sorted_list_insert.sv =====
// sorted list insert: ordered key set in a node pool, driven by a microcoded sequencer
// steps: check for a full pool, walk past the smaller keys (at most 63), reject a
//   duplicate or else allocate and link a node, then emit the result
// one key at a time: no new request is taken until the result is loaded for output; the walk
//   visits one node per cycle through the registered read port of the node memories
// reset: list empty, free list chained in index order, link valid bits cleared at once
module sorted_list_insert (
  input logic       clk,
  input logic       rst,
  sli_req_if.sink   req,
  sli_rsp_if.source rsp
);

  // sequencer
  logic [sli_pkg::STEP_W-1:0] pc;
  logic [sli_pkg::STEP_W-1:0] pc_next;
  sli_pkg::uword_t            uw;
  logic                       taken;

  // datapath registers
  logic [sli_pkg::KEY_BITS-1:0] key;
  sli_pkg::ptr_t                cur;
  sli_pkg::ptr_t                cur_next;
  sli_pkg::ptr_t                prev;
  sli_pkg::ptr_t                fresh;
  sli_pkg::ptr_t                list_head;
  sli_pkg::ptr_t                free_head;
  logic [sli_pkg::RANK_W-1:0]   smaller;
  logic [sli_pkg::STAT_W-1:0]   status;

  // node pool: key store has no reset, link store falls back to the chained free list
  logic [sli_pkg::KEY_BITS-1:0] key_mem  [sli_pkg::POOL_SIZE];
  sli_pkg::ptr_t                link_mem [sli_pkg::POOL_SIZE];
  logic [sli_pkg::POOL_SIZE-1:0] link_vld;

  logic [sli_pkg::IDX_W-1:0]    rd_idx;
  logic [sli_pkg::IDX_W-1:0]    rd_idx_q;
  logic [sli_pkg::KEY_BITS-1:0] key_q;
  sli_pkg::ptr_t                link_q;
  logic                         link_hit;
  sli_pkg::ptr_t                link_rd;

  logic                         lwr_en;
  logic [sli_pkg::IDX_W-1:0]    lwr_idx;
  sli_pkg::ptr_t                lwr_data;

  logic accept;
  logic cur_ok;
  logic prev_ok;
  logic load_out;
  logic rsp_vld;
  logic [sli_pkg::STAT_W-1:0] rsp_status;
  logic [sli_pkg::RANK_W-1:0] rsp_rank;

  assign uw       = sli_pkg::ucode(pc);
  assign accept   = req.valid && req.ready;
  assign cur_ok   = (cur < sli_pkg::NONE_IDX);
  assign prev_ok  = (prev < sli_pkg::NONE_IDX);

  // a link entry never written still holds its reset chain value
  assign link_rd = link_hit ? link_q : (sli_pkg::PTR_W'(rd_idx_q) + sli_pkg::PTR_W'(1));

  // jump condition selected by the control word
  always_comb begin
    case (uw.cond)
      sli_pkg::C_NEVER:  taken = 1'b0;
      sli_pkg::C_ALWAYS: taken = 1'b1;
      sli_pkg::C_NOREQ:  taken = !req.valid;
      sli_pkg::C_FULL:   taken = (free_head >= sli_pkg::NONE_IDX);
      sli_pkg::C_WALK:   taken = cur_ok && (smaller < sli_pkg::RANK_W'(sli_pkg::POOL_SIZE))
                                 && (key_q < key);
      sli_pkg::C_DUP:    taken = cur_ok && (key_q == key);
      sli_pkg::C_OBUSY:  taken = rsp_vld && !rsp.ready;
      default:           taken = 1'b0;
    endcase
  end

  assign pc_next  = taken ? uw.jmp : pc + sli_pkg::STEP_W'(1);
  assign load_out = uw.emit && !taken;

  // the read address follows the next walk position so a node is compared every cycle
  always_comb begin
    if (accept) begin
      cur_next = list_head;
    end else if (uw.adv && taken) begin
      cur_next = link_rd;
    end else begin
      cur_next = cur;
    end
  end

  assign rd_idx = uw.rsel_free ? free_head[sli_pkg::IDX_W-1:0] : cur_next[sli_pkg::IDX_W-1:0];

  // alloc writes the fresh node's link (the node the walk stopped on), link step patches prev
  assign lwr_en   = uw.alloc || (uw.link && prev_ok);
  assign lwr_idx  = uw.alloc ? free_head[sli_pkg::IDX_W-1:0] : prev[sli_pkg::IDX_W-1:0];
  assign lwr_data = uw.alloc ? cur : fresh;

  always_ff @(posedge clk) begin
    if (uw.alloc) begin
      key_mem[free_head[sli_pkg::IDX_W-1:0]] <= key;
    end
    if (lwr_en) begin
      link_mem[lwr_idx] <= lwr_data;
    end
    key_q    <= key_mem[rd_idx];
    link_q   <= link_mem[rd_idx];
    link_hit <= link_vld[rd_idx];
    rd_idx_q <= rd_idx;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= sli_pkg::S_IDLE;
      cur       <= sli_pkg::NONE_IDX;
      list_head <= sli_pkg::NONE_IDX;
      free_head <= '0;
      link_vld  <= '0;
      rsp_vld   <= 1'b0;
    end else begin
      pc  <= pc_next;
      cur <= cur_next;
      if (uw.alloc) begin
        free_head <= link_rd;
      end
      if (uw.link && !prev_ok) begin
        list_head <= fresh;
      end
      if (lwr_en) begin
        link_vld[lwr_idx] <= 1'b1;
      end
      if (load_out) begin
        rsp_vld <= 1'b1;
      end else if (rsp.ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key     <= req.new_key;
      prev    <= sli_pkg::NONE_IDX;
      smaller <= '0;
      status  <= sli_pkg::ST_OK;
    end else begin
      if (uw.adv && taken) begin
        prev    <= cur;
        smaller <= smaller + sli_pkg::RANK_W'(1);
      end
      if (uw.st_jmp && taken) begin
        status <= uw.st;
      end
    end
    if (uw.alloc) begin
      fresh <= free_head;
    end
    if (load_out) begin
      rsp_status <= status;
      rsp_rank   <= smaller;
    end
  end

  assign req.ready  = uw.in_rdy;
  assign rsp.valid  = rsp_vld;
  assign rsp.status = rsp_status;
  assign rsp.rank   = rsp_rank;

endmodule

// ===== design/sli_checker.sv =====
// port-level checker for the sorted list insert block, with its bind
`include "assert_macros.svh"

module sli_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [sli_pkg::STAT_W-1:0] rsp_status,
  input logic [sli_pkg::RANK_W-1:0] rsp_rank
);

  // a stalled result holds
  `SLI_ASSERT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_rank)))

  // only the three defined status codes leave the block
  `SLI_ASSERT_IMP(a_status_code, clk, rst, rsp_valid, (rsp_status == sli_pkg::ST_OK || rsp_status == sli_pkg::ST_FULL || rsp_status == sli_pkg::ST_DUP))

  // a full pool reports no smaller keys
  `SLI_ASSERT_IMP(a_full_rank, clk, rst, (rsp_valid && rsp_status == sli_pkg::ST_FULL), (rsp_rank == '0))

  // rank never reaches the pool size
  `SLI_ASSERT_IMP(a_rank_range, clk, rst, rsp_valid, (rsp_rank < sli_pkg::RANK_W'(sli_pkg::POOL_SIZE)))

  // one key in flight: request channel closes straight after a transaction
  `SLI_ASSERT(a_one_key, clk, rst, (req_valid && req_ready) |=> !req_ready)

endmodule

bind sorted_list_insert sli_checker u_sli_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_rank   (rsp.rank)
);

// ===== verif/tb_top.sv =====
// self-checking testbench for sorted_list_insert: key stimulus, ordered-set prediction, result check
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 8;
  localparam int RANDOM_KEYS = 1950;
  // longest quiet spell on both channels: walk of 63 nodes plus allocate, link and
  // emit, plus the worst sender gap and receiver stall, with margin
  localparam int STALL_LIMIT = 2000;
  // drain time after the last result, a little over the longest insert
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [sli_pkg::STAT_W-1:0] status;
    logic [sli_pkg::RANK_W-1:0] rank;
  } insert_outcome_t;

  logic clk;
  logic rst;

  sli_req_if key_ch ();
  sli_rsp_if outcome_ch ();

  sorted_list_insert u_top (
    .clk (clk),
    .rst (rst),
    .req (key_ch),
    .rsp (outcome_ch)
  );

  // predicted contents of the ordered set, ascending
  logic [sli_pkg::KEY_BITS-1:0] stored_keys[$];
  // outcomes still owed by the block, oldest first
  insert_outcome_t              outcome_q[$];

  int   mismatches;
  int   keys_sent;
  int   n_inserted;
  int   n_dup;
  int   n_full;
  // when set, neither side idles: back-to-back stretches
  logic no_idle;

  // every input at a known value from time zero
  initial begin
    rst              = 1'b1;
    key_ch.valid     = 1'b0;
    key_ch.new_key   = '0;
    outcome_ch.ready = 1'b0;
    no_idle          = 1'b0;
    mismatches       = 0;
    keys_sent        = 0;
    n_inserted       = 0;
    n_dup            = 0;
    n_full           = 0;
  end

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ordered-set prediction: full check first, then count smaller keys,
  // then either a duplicate reject or an insert at that position
  function automatic insert_outcome_t predict_insert(input logic [sli_pkg::KEY_BITS-1:0] key);
    insert_outcome_t o;
    int              pos;
    pos = 0;
    if (stored_keys.size() >= sli_pkg::POOL_SIZE) begin
      // full pool: rank reads zero, nothing stored
      o.status = sli_pkg::ST_FULL;
      o.rank   = '0;
      return o;
    end
    while (pos < stored_keys.size() && stored_keys[pos] < key) pos++;
    o.rank = sli_pkg::RANK_W'(pos);
    if (pos < stored_keys.size() && stored_keys[pos] == key) begin
      o.status = sli_pkg::ST_DUP;
    end else begin
      stored_keys.insert(pos, key);
      o.status = sli_pkg::ST_OK;
    end
    return o;
  endfunction

  // one request transaction: optional gap, then hold valid until accepted
  task automatic send_key(input logic [sli_pkg::KEY_BITS-1:0] key);
    int              gap;
    insert_outcome_t o;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      key_ch.valid <= 1'b0;
    end
    @(negedge clk);
    key_ch.valid   <= 1'b1;
    key_ch.new_key <= key;
    do @(posedge clk); while (!(key_ch.valid && key_ch.ready));
    o = predict_insert(key);
    outcome_q.push_back(o);
    keys_sent++;
    case (o.status)
      sli_pkg::ST_OK:  n_inserted++;
      sli_pkg::ST_DUP: n_dup++;
      default:         n_full++;
    endcase
  endtask

  // sender goes quiet until every owed outcome has come back
  task automatic wait_all_outcomes();
    @(negedge clk);
    key_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
  endtask

  // a random key already in the set, or a fresh random one when the set is empty
  function automatic logic [sli_pkg::KEY_BITS-1:0] pick_stored();
    if (stored_keys.size() == 0) return $urandom();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // extremes of the key range, inserts at head, tail and middle
  task automatic test_edge_keys();
    send_key(32'hFFFF_FFFF);  // into the empty list
    send_key(32'h0000_0000);  // new head
    send_key(32'h8000_0000);  // middle
    send_key(32'h7FFF_FFFF);
    send_key(32'hFFFF_FFFE);  // just ahead of the tail
    send_key(32'h0000_0001);
  endtask

  // duplicates at the head, the tail and in the middle of the list, plus two fresh keys, one sent twice
  task automatic test_duplicates();
    wait_all_outcomes();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h0000_0001);
    send_key(32'h5555_5555);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
  endtask

  // mostly duplicates, which walk the list at every depth without using nodes,
  // plus a trickle of fresh keys and near neighbours so the pool fills slowly
  task automatic test_random_mix();
    int                           r;
    logic [sli_pkg::KEY_BITS-1:0] key;
    for (int i = 0; i < RANDOM_KEYS; i++) begin
      if (i % 128 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (stored_keys.size() == 0 || r < 2) begin
        key = $urandom();
      end else if (r == 2) begin
        key = pick_stored();
        key = $urandom_range(0, 1) ? key + 1'b1 : key - 1'b1;
      end else begin
        key = pick_stored();
      end
      send_key(key);
    end
    no_idle = 1'b0;
  endtask

  // top up the pool, then check that full rejects come ahead of duplicates
  task automatic test_full_pool();
    wait_all_outcomes();
    while (stored_keys.size() < sli_pkg::POOL_SIZE) send_key($urandom());
    wait_all_outcomes();
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) begin
      send_key($urandom_range(0, 1) ? pick_stored() : $urandom());
    end
  endtask

  // result side: draw a stall per transaction, then hold ready until accepted
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        outcome_ch.ready <= 1'b0;
      end
      @(negedge clk);
      outcome_ch.ready <= 1'b1;
      do @(posedge clk); while (!(outcome_ch.valid && outcome_ch.ready));
    end
  end

  // compare every result transaction with the oldest owed outcome
  always @(posedge clk) begin
    insert_outcome_t want;
    if (!rst && outcome_ch.valid && outcome_ch.ready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d rank %0d", outcome_ch.status,
                   outcome_ch.rank);
      end else begin
        want = outcome_q.pop_front();
        if (outcome_ch.status !== want.status || outcome_ch.rank !== want.rank) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status %0d rank %0d, got status %0d rank %0d",
                     want.status, want.rank, outcome_ch.status, outcome_ch.rank);
        end
      end
    end
  end

  // watchdog: too long without any transaction on either channel ends the run
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (key_ch.valid && key_ch.ready) || (outcome_ch.valid && outcome_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_edge_keys();
    test_duplicates();
    test_random_mix();
    test_full_pool();

    // let the last result land, then a little longer
    wait_all_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outcome_q.size() != 0) begin
      mismatches += outcome_q.size();
      $display("%0d outcomes never arrived", outcome_q.size());
    end

    $display("run covered %0d keys: %0d inserted, %0d duplicate, %0d rejected as full",
             keys_sent, n_inserted, n_dup, n_full);
    $display("set size at end %0d of %0d nodes, %0d mismatches", stored_keys.size(),
             sli_pkg::POOL_SIZE, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sli_pkg.sv
design/sli_if.sv
design/sorted_list_insert.sv
design/sli_checker.sv
verif/tb_top.sv
